FILE: rtl/core/msc_pkg.sv
`default_nettype none
package msc_pkg;

  // configuration port
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned CFG_W    = 5;
  localparam logic        REG_ROWS = 1'b0;
  localparam logic        REG_COLS = 1'b1;

  // running property flag bits
  localparam int unsigned FLAG_W     = 6;
  localparam int unsigned FLAG_ZERO  = 0;
  localparam int unsigned FLAG_OFFD  = 1;
  localparam int unsigned FLAG_IDENT = 2;
  localparam int unsigned FLAG_SYMM  = 3;
  localparam int unsigned FLAG_UPPER = 4;
  localparam int unsigned FLAG_LOWER = 5;

  // position class of one element, worked out by the front end
  typedef struct packed {
    logic last;
    logic square;
    logic on_diag;
    logic below;
    logic above;
    logic check_mirror;
  } elem_ctl_t;

  // one classification result
  typedef struct packed {
    logic square;
    logic all_zero;
    logic diagonal;
    logic identity;
    logic symmetric;
    logic upper_triangular;
    logic lower_triangular;
    logic triangular;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/core/msc_front.sv
`default_nettype none
module msc_front #(
  parameter int unsigned MAX_DIM = 16,
  parameter int unsigned VW      = 32,
  parameter int unsigned DIM_W   = 4,
  parameter int unsigned CNT_W   = 5,
  parameter int unsigned ADDR_W  = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                restart,
  input  wire logic [CNT_W-1:0]    rows_eff,
  input  wire logic [CNT_W-1:0]    cols_eff,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [31:0]         in_element_value,
  input  wire logic                q_full,
  output logic                     push,
  output logic [VW-1:0]            push_value,
  output logic [ADDR_W-1:0]        push_wr_addr,
  output logic [ADDR_W-1:0]        push_rd_addr,
  output msc_pkg::elem_ctl_t       push_ctl
);

  localparam int unsigned PW = DIM_W + 1;

  logic [DIM_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] col_r, col_nxt;
  logic [PW-1:0]    row_inc, col_inc;
  logic             row_end, col_end;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // position of the incoming element
  assign row_inc = {1'b0, row_r} + PW'(1);
  assign col_inc = {1'b0, col_r} + PW'(1);
  assign col_end = (col_inc == PW'(cols_eff));
  assign row_end = (row_inc == PW'(rows_eff));

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (col_end) begin
      col_nxt = '0;
      row_nxt = row_end ? '0 : row_inc[DIM_W-1:0];
    end else begin
      col_nxt = col_inc[DIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      row_r <= '0;
      col_r <= '0;
    end else if (push) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // request payload for the back end
  assign push_value   = in_element_value[VW-1:0];
  assign push_wr_addr = ADDR_W'(row_r) * ADDR_W'(MAX_DIM) + ADDR_W'(col_r);
  assign push_rd_addr = ADDR_W'(col_r) * ADDR_W'(MAX_DIM) + ADDR_W'(row_r);

  always_comb begin
    push_ctl.last         = col_end && row_end;
    push_ctl.square       = (rows_eff == cols_eff);
    push_ctl.on_diag      = (row_r == col_r);
    push_ctl.below        = (row_r > col_r);
    push_ctl.above        = (row_r < col_r);
    push_ctl.check_mirror = (rows_eff == cols_eff) && (row_r > col_r);
  end

endmodule
`default_nettype wire

FILE: rtl/core/msc_queue.sv
`default_nettype none
module msc_queue #(
  parameter int unsigned DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic                   not_empty,
  output logic [DATA_W-1:0]      pop_data
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = 2;

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]    fill_r, fill_nxt;

  assign full      = (fill_r == (PTR_W+1)'(DEPTH));
  assign not_empty = (fill_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill level
  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + (PTR_W+1)'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      fill_r <= fill_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/msc_back.sv
`default_nettype none
module msc_back #(
  parameter int unsigned VW     = 32,
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned DEPTH  = 256
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                restart,
  input  wire logic                q_valid,
  output logic                     q_pop,
  input  wire logic [VW-1:0]       q_value,
  input  wire logic [ADDR_W-1:0]   q_wr_addr,
  input  wire logic [ADDR_W-1:0]   q_rd_addr,
  input  wire msc_pkg::elem_ctl_t  q_ctl,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output msc_pkg::result_t         out_result
);

  logic [VW-1:0]              store [DEPTH];
  logic [VW-1:0]              mirror_r;
  logic [VW-1:0]              b_value_r;
  msc_pkg::elem_ctl_t         b_ctl_r;
  logic                       b_valid_r;
  logic [msc_pkg::FLAG_W-1:0] flags_r, flags_nxt;
  logic                       out_valid_r;
  msc_pkg::result_t           result_r, result_nxt;
  logic                       b_go, advance, complete;
  logic                       nz, is_one;

  // the check stage only waits when it holds a matrix's last element and the output is busy
  assign b_go     = !b_ctl_r.last || !out_valid_r || out_ready;
  assign advance  = !b_valid_r || b_go;
  assign q_pop    = q_valid && advance;
  assign complete = b_valid_r && b_go;

  // element store: write own entry, read mirror entry
  always_ff @(posedge clk) begin
    if (q_pop) begin
      store[q_wr_addr] <= q_value;
      mirror_r         <= store[q_rd_addr];
      b_value_r        <= q_value;
      b_ctl_r          <= q_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (advance) begin
      b_valid_r <= q_pop;
    end
  end

  // property flag update
  assign nz     = (b_value_r != '0);
  assign is_one = (b_value_r == VW'(1));

  always_comb begin
    flags_nxt = flags_r;
    if (nz) begin
      flags_nxt[msc_pkg::FLAG_ZERO] = 1'b0;
      if (!b_ctl_r.on_diag) flags_nxt[msc_pkg::FLAG_OFFD]  = 1'b0;
      if (b_ctl_r.below)    flags_nxt[msc_pkg::FLAG_UPPER] = 1'b0;
      if (b_ctl_r.above)    flags_nxt[msc_pkg::FLAG_LOWER] = 1'b0;
    end
    if (b_ctl_r.on_diag ? !is_one : nz) begin
      flags_nxt[msc_pkg::FLAG_IDENT] = 1'b0;
    end
    if (b_ctl_r.check_mirror && (mirror_r != b_value_r)) begin
      flags_nxt[msc_pkg::FLAG_SYMM] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      flags_r <= '1;
    end else if (complete) begin
      flags_r <= b_ctl_r.last ? '1 : flags_nxt;
    end
  end

  // result assembly
  always_comb begin
    result_nxt.square           = b_ctl_r.square;
    result_nxt.all_zero         = flags_nxt[msc_pkg::FLAG_ZERO];
    result_nxt.diagonal         = b_ctl_r.square && flags_nxt[msc_pkg::FLAG_OFFD];
    result_nxt.identity         = b_ctl_r.square && flags_nxt[msc_pkg::FLAG_IDENT];
    result_nxt.symmetric        = b_ctl_r.square && flags_nxt[msc_pkg::FLAG_SYMM];
    result_nxt.upper_triangular = flags_nxt[msc_pkg::FLAG_UPPER];
    result_nxt.lower_triangular = flags_nxt[msc_pkg::FLAG_LOWER];
    result_nxt.triangular       = flags_nxt[msc_pkg::FLAG_UPPER]
                                  || flags_nxt[msc_pkg::FLAG_LOWER];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (complete && b_ctl_r.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (complete && b_ctl_r.last) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = result_r;

endmodule
`default_nettype wire

FILE: rtl/core/matrix_structure_classifier_unit.sv
// a matrix's result is registered after its last element passes the request queue and check stage
// throughput: one element per cycle unless stalled; back end writes store, reads mirror together
// results: one per matrix of row_count x column_count elements
// a full 4-entry request queue or a waiting result stalls the input
// reset: synchronous, active low; clears positions, queue and output valid, sets the flags
// and both dimension registers to 1; element store contents stay undefined
`default_nettype none
module matrix_structure_classifier_unit #(
  parameter int unsigned MAX_DIM    = 16,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [31:0]                in_element_value,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_square,
  output logic                            out_all_zero,
  output logic                            out_diagonal,
  output logic                            out_identity,
  output logic                            out_symmetric,
  output logic                            out_upper_triangular,
  output logic                            out_lower_triangular,
  output logic                            out_triangular,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [msc_pkg::APB_AW-1:0] paddr,
  input  wire logic [msc_pkg::APB_DW-1:0] pwdata,
  output logic [msc_pkg::APB_DW-1:0]      prdata,
  output logic                            pready
);

  localparam int unsigned VW     = (ELEM_WIDTH < 32) ? ELEM_WIDTH : 32;
  localparam int unsigned DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned CNT_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM + 1) : 1;
  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CTL_W  = $bits(msc_pkg::elem_ctl_t);
  localparam int unsigned Q_W    = VW + 2 * ADDR_W + CTL_W;

  logic [msc_pkg::CFG_W-1:0] row_count_r, column_count_r;
  logic [CNT_W-1:0]          rows_eff, cols_eff;
  logic                      cfg_wr;

  logic                      push, q_full, q_valid, q_pop;
  logic [VW-1:0]             push_value, q_value;
  logic [ADDR_W-1:0]         push_wr_addr, push_rd_addr, q_wr_addr, q_rd_addr;
  msc_pkg::elem_ctl_t        push_ctl, q_ctl;
  logic [Q_W-1:0]            q_in, q_out;
  msc_pkg::result_t          result;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= msc_pkg::CFG_W'(1);
      column_count_r <= msc_pkg::CFG_W'(1);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        msc_pkg::REG_ROWS: row_count_r    <= pwdata[msc_pkg::CFG_W-1:0];
        msc_pkg::REG_COLS: column_count_r <= pwdata[msc_pkg::CFG_W-1:0];
        default:           row_count_r    <= row_count_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      msc_pkg::REG_ROWS: prdata = msc_pkg::APB_DW'(row_count_r);
      msc_pkg::REG_COLS: prdata = msc_pkg::APB_DW'(column_count_r);
      default:           prdata = '0;
    endcase
  end

  // dimensions clamped to 1..MAX_DIM
  always_comb begin
    priority if (row_count_r == '0) begin
      rows_eff = CNT_W'(1);
    end else if (int'(row_count_r) > MAX_DIM) begin
      rows_eff = CNT_W'(MAX_DIM);
    end else begin
      rows_eff = CNT_W'(row_count_r);
    end
    priority if (column_count_r == '0) begin
      cols_eff = CNT_W'(1);
    end else if (int'(column_count_r) > MAX_DIM) begin
      cols_eff = CNT_W'(MAX_DIM);
    end else begin
      cols_eff = CNT_W'(column_count_r);
    end
  end

  // front end: position tracking and classification
  msc_front #(
    .MAX_DIM (MAX_DIM),
    .VW      (VW),
    .DIM_W   (DIM_W),
    .CNT_W   (CNT_W),
    .ADDR_W  (ADDR_W)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .restart          (cfg_wr),
    .rows_eff         (rows_eff),
    .cols_eff         (cols_eff),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_element_value (in_element_value),
    .q_full           (q_full),
    .push             (push),
    .push_value       (push_value),
    .push_wr_addr     (push_wr_addr),
    .push_rd_addr     (push_rd_addr),
    .push_ctl         (push_ctl)
  );

  // request queue between front and back
  assign q_in = {push_value, push_wr_addr, push_rd_addr, push_ctl};
  assign {q_value, q_wr_addr, q_rd_addr, q_ctl} = q_out;

  msc_queue #(
    .DATA_W (Q_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_out)
  );

  // back end: store access, flag update, result
  msc_back #(
    .VW     (VW),
    .ADDR_W (ADDR_W),
    .DEPTH  (DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (cfg_wr),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_value    (q_value),
    .q_wr_addr  (q_wr_addr),
    .q_rd_addr  (q_rd_addr),
    .q_ctl      (q_ctl),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (result)
  );

  assign out_square           = result.square;
  assign out_all_zero         = result.all_zero;
  assign out_diagonal         = result.diagonal;
  assign out_identity         = result.identity;
  assign out_symmetric        = result.symmetric;
  assign out_upper_triangular = result.upper_triangular;
  assign out_lower_triangular = result.lower_triangular;
  assign out_triangular       = result.triangular;

endmodule
`default_nettype wire

FILE: rtl/core/msc_checker.sv
`default_nettype none
module msc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_square,
  input wire logic out_all_zero,
  input wire logic out_diagonal,
  input wire logic out_identity,
  input wire logic out_symmetric,
  input wire logic out_upper_triangular,
  input wire logic out_lower_triangular,
  input wire logic out_triangular
);

  // a stalled result stays valid; its square, zero, identity, symmetric and triangular flags hold
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_square) && $stable(out_all_zero)
      && $stable(out_identity) && $stable(out_symmetric) && $stable(out_triangular))
    else $error("result changed while stalled");

  // identity implies diagonal
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_identity |-> out_diagonal)
    else $error("identity without diagonal");

  // diagonal implies square and both triangular forms
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_diagonal |-> out_square && out_upper_triangular
      && out_lower_triangular)
    else $error("diagonal inconsistent with triangular flags");

  // zero matrix is both triangular forms; symmetric needs square
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_all_zero || (out_upper_triangular && out_lower_triangular))
      && (!out_symmetric || out_square))
    else $error("zero or symmetric flag inconsistent");

  // triangular is upper or lower
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_triangular == (out_upper_triangular || out_lower_triangular))
    else $error("triangular flag mismatch");

endmodule

bind matrix_structure_classifier_unit msc_checker u_msc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_square           (out_square),
  .out_all_zero         (out_all_zero),
  .out_diagonal         (out_diagonal),
  .out_identity         (out_identity),
  .out_symmetric        (out_symmetric),
  .out_upper_triangular (out_upper_triangular),
  .out_lower_triangular (out_lower_triangular),
  .out_triangular       (out_triangular)
);
`default_nettype wire
